### rtl/core/plc_pkg.sv
// plc_pkg: shared types and constants for the polygon line clipper
// no dependencies

package plc_pkg;

    localparam int unsigned RegLinePointX = 0;
    localparam int unsigned RegLinePointY = 1;
    localparam int unsigned RegLineDirX   = 2;
    localparam int unsigned RegLineDirY   = 3;
    localparam int unsigned CfgIdxWidth   = 2;

    localparam int unsigned NormWidth = 48;
    localparam int unsigned PosWidth  = 48;
    localparam int unsigned ProjWidth = 64;
    localparam int unsigned LaneSlot  = 16;
    localparam int unsigned NumLanes  = 10;
    localparam int unsigned TWidth    = 17;
    localparam logic [TWidth-1:0] TOne = 17'h10000;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_DIV,
        BK_LERP,
        BK_EMIT_INT,
        BK_EMIT_END,
        BK_EMIT_MARK
    } t_bk_state;

endpackage

### rtl/core/polygon_line_clipper.sv
// polygon_line_clipper: top level, front end, job queue and back end
// depends on plc_pkg, plc_front, plc_queue, plc_back
//
// One Sutherland-Hodgman clip stage against a line. The front end takes a new vertex
// only once it is idle again, after the side test and edge job of the previous one; the
// last vertex of a polygon also queues the closing edge. In the back end an edge job
// that does not cross the line leaves the divide state at once, and one that crosses
// first runs the 17-bit restoring divider for t and the one-value-a-cycle interpolator
// over twelve values; every result word is then held until it is taken. The queue lets
// the front end move on while the back end works.

module polygon_line_clipper
    import plc_pkg::*;
#(
    parameter int SCREEN_WIDTH = 24,
    parameter int ATTR_WIDTH   = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [CfgIdxWidth-1:0]         i_cfg_index,
    input  logic [SCREEN_WIDTH-1:0]        i_cfg_data,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [SCREEN_WIDTH-1:0] i_screen_x,
    input  logic signed [SCREEN_WIDTH-1:0] i_screen_y,
    input  logic [NormWidth-1:0]           i_normal_lanes,
    input  logic [PosWidth-1:0]            i_position_lanes,
    input  logic [ProjWidth-1:0]           i_projected_lanes,
    input  logic                           i_last_vertex,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [SCREEN_WIDTH-1:0] o_out_screen_x,
    output logic signed [SCREEN_WIDTH-1:0] o_out_screen_y,
    output logic [NormWidth-1:0]           o_out_normal_lanes,
    output logic [PosWidth-1:0]            o_out_position_lanes,
    output logic [ProjWidth-1:0]           o_out_projected_lanes,
    output logic                           o_vertex_valid,
    output logic                           o_polygon_end
);
    localparam int SW = SCREEN_WIDTH;
    localparam int VW = 2 * SW + NormWidth + PosWidth + ProjWidth;
    localparam int JW = 2 * VW + 5;

    logic signed [SW-1:0] r_px, r_py, r_dx, r_dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_px <= '0;
            r_py <= '0;
            r_dx <= SW'(1);
            r_dy <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CfgIdxWidth'(RegLinePointX): r_px <= i_cfg_data;
                CfgIdxWidth'(RegLinePointY): r_py <= i_cfg_data;
                CfgIdxWidth'(RegLineDirX):   r_dx <= i_cfg_data;
                CfgIdxWidth'(RegLineDirY):   r_dy <= i_cfg_data;
                default: r_dy <= r_dy;
            endcase
        end
    end

    logic          w_fj_valid, w_fj_ready, w_bj_valid, w_bj_ready;
    logic [JW-1:0] w_fj, w_bj;
    logic [VW-1:0] w_out;

    plc_front #(.SW(SW), .VW(VW), .JW(JW)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_px(r_px), .i_py(r_py), .i_dx(r_dx), .i_dy(r_dy),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_vtx({i_screen_x, i_screen_y, i_normal_lanes, i_position_lanes,
                i_projected_lanes}),
        .i_last(i_last_vertex),
        .o_job_valid(w_fj_valid), .o_job(w_fj), .i_job_ready(w_fj_ready)
    );

    plc_queue #(.JW(JW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_fj_valid), .o_ready(w_fj_ready), .i_data(w_fj),
        .o_valid(w_bj_valid), .i_ready(w_bj_ready), .o_data(w_bj)
    );

    plc_back #(.SW(SW), .AW(ATTR_WIDTH), .VW(VW), .JW(JW)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_px(r_px), .i_py(r_py), .i_dx(r_dx), .i_dy(r_dy),
        .i_job_valid(w_bj_valid), .o_job_ready(w_bj_ready), .i_job(w_bj),
        .o_valid(o_valid), .i_ready(i_ready), .o_vtx(w_out),
        .o_vertex_valid(o_vertex_valid), .o_polygon_end(o_polygon_end)
    );

    assign o_out_screen_x        = w_out[VW-1 -: SW];
    assign o_out_screen_y        = w_out[VW-SW-1 -: SW];
    assign o_out_normal_lanes    = w_out[ProjWidth+PosWidth +: NormWidth];
    assign o_out_position_lanes  = w_out[ProjWidth +: PosWidth];
    assign o_out_projected_lanes = w_out[ProjWidth-1:0];
endmodule

### rtl/core/plc_front.sv
// plc_front: accepts vertices, computes side flags, keeps first and previous vertex
// and queues edge jobs for the back end; depends on plc_pkg

module plc_front
    import plc_pkg::*;
#(
    parameter int SW = 24,
    parameter int VW = 2 * SW + NormWidth + PosWidth + ProjWidth,
    parameter int JW = 2 * VW + 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic signed [SW-1:0] i_px,
    input  logic signed [SW-1:0] i_py,
    input  logic signed [SW-1:0] i_dx,
    input  logic signed [SW-1:0] i_dy,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [VW-1:0]     i_vtx,
    input  logic              i_last,
    output logic              o_job_valid,
    output logic [JW-1:0]     o_job,
    input  logic              i_job_ready
);
    // job: {p1, p2, in1, in2, do_edge, mark_end, closing}
    localparam int PW = 2 * SW + 2;

    logic [VW-1:0] r_first, r_prev;
    logic          r_first_in, r_prev_in, r_have_first;
    logic [VW-1:0] r_cur;
    logic          r_cur_last;
    logic          r_end_early;
    logic [1:0]    r_phase;   // phases in code order idle, compute side, edge job, closing job
    logic signed [SW:0] r_ex, r_ey;
    logic signed [PW-1:0] r_a, r_b;

    logic signed [SW-1:0] w_x, w_y;
    logic          w_cur_in, w_edge_mark;
    assign w_x = i_vtx[VW-1 -: SW];
    assign w_y = i_vtx[VW-SW-1 -: SW];
    assign w_cur_in = (r_a < r_b);
    // closing edge gives nothing, so the end flag rides on this edge's intersection
    assign w_edge_mark = r_have_first && r_cur_last && !w_cur_in && !r_first_in
                         && r_prev_in;

    assign o_ready = (r_phase == 2'd0);

    always_comb begin
        o_job_valid = 1'b0;
        o_job       = '0;
        if (r_phase == 2'd2 && r_have_first) begin
            o_job_valid = 1'b1;
            o_job = {r_prev, r_cur, r_prev_in, w_cur_in, 1'b1, w_edge_mark, 1'b0};
        end else if (r_phase == 2'd3) begin
            o_job_valid = 1'b1;
            o_job = {r_prev, r_first, r_prev_in, r_first_in, 1'b1, !r_end_early, 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= 2'd0;
            r_have_first <= 1'b0;
            r_first_in   <= 1'b0;
            r_prev_in    <= 1'b0;
        end else begin
            case (r_phase)
                2'd0: begin
                    if (i_valid) begin
                        r_cur      <= i_vtx;
                        r_cur_last <= i_last;
                        r_ex       <= (SW+1)'(w_x) - (SW+1)'(i_px);
                        r_ey       <= (SW+1)'(w_y) - (SW+1)'(i_py);
                        r_phase    <= 2'd1;
                    end
                end
                2'd1: begin
                    r_a     <= PW'(r_ex) * PW'(i_dy);
                    r_b     <= PW'(r_ey) * PW'(i_dx);
                    r_phase <= 2'd2;
                end
                2'd2: begin
                    if (!r_have_first || i_job_ready) begin
                        if (!r_have_first) begin
                            r_first    <= r_cur;
                            r_first_in <= w_cur_in;
                        end
                        r_end_early  <= w_edge_mark;
                        r_prev       <= r_cur;
                        r_prev_in    <= w_cur_in;
                        r_have_first <= 1'b1;
                        r_phase      <= r_cur_last ? 2'd3 : 2'd0;
                    end
                end
                default: begin
                    if (i_job_ready) begin
                        r_have_first <= 1'b0;
                        r_phase      <= 2'd0;
                    end
                end
            endcase
        end
    end
endmodule

### rtl/core/plc_queue.sv
// plc_queue: two-entry job queue between front and back end
// depends on plc_pkg

module plc_queue
    import plc_pkg::*;
#(
    parameter int JW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [JW-1:0] i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [JW-1:0] o_data
);
    logic [JW-1:0] r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

### rtl/core/plc_back.sv
// plc_back: carries out edge jobs: division for t, lane interpolation, result output
// depends on plc_pkg

module plc_back
    import plc_pkg::*;
#(
    parameter int SW = 24,
    parameter int AW = 16,
    parameter int VW = 2 * SW + NormWidth + PosWidth + ProjWidth,
    parameter int JW = 2 * VW + 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic signed [SW-1:0] i_px,
    input  logic signed [SW-1:0] i_py,
    input  logic signed [SW-1:0] i_dx,
    input  logic signed [SW-1:0] i_dy,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  logic [JW-1:0]     i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [VW-1:0]     o_vtx,
    output logic              o_vertex_valid,
    output logic              o_polygon_end
);
    localparam int PW = 2 * SW + 2;
    localparam int MW = PW + 1;
    localparam int DW = SW + 1;

    t_bk_state r_state, n_state;
    logic [VW-1:0] r_p1, r_p2;
    logic r_in1, r_in2, r_mark;
    logic [1:0] r_sub;
    logic [MW-1:0] r_m1, r_m2, r_rem, r_den;
    logic r_n1, r_n2;
    logic [TWidth-1:0] r_q;
    logic [4:0] r_bit;
    logic [3:0] r_lane;
    logic [VW-1:0] r_int;
    logic signed [DW-1:0] r_e1x, r_e1y, r_e2x, r_e2y;
    logic signed [PW-1:0] r_a1, r_b1, r_a2, r_b2;

    logic [VW-1:0] w_p1, w_p2;
    assign w_p1 = i_job[JW-1 -: VW];
    assign w_p2 = i_job[JW-VW-1 -: VW];

    // lane k value extraction
    function automatic logic signed [SW:0] get_val(input logic [VW-1:0] v, input logic [3:0] k);
        logic signed [SW:0] r;
        logic [LaneSlot-1:0] s;
        r = '0;
        s = '0;
        if (k == 4'd0) r = (SW+1)'($signed(v[VW-1 -: SW]));
        else if (k == 4'd1) r = (SW+1)'($signed(v[VW-SW-1 -: SW]));
        else begin
            s = v[(32'(k) - 2) * LaneSlot +: LaneSlot];
            r = (SW+1)'($signed(s[AW-1:0]));
        end
        return r;
    endfunction

    logic signed [SW:0] w_va, w_vb;
    logic signed [SW+1:0] w_d;
    logic [SW+1:0] w_mag;
    logic [SW+TWidth+1:0] w_prod;
    logic signed [SW+1:0] w_res;
    assign w_va   = get_val(r_p1, r_lane);
    assign w_vb   = get_val(r_p2, r_lane);
    assign w_d    = (SW+2)'(w_vb) - (SW+2)'(w_va);
    assign w_mag  = w_d[SW+1] ? (SW+2)'(-w_d) : (SW+2)'(w_d);
    assign w_prod = (SW+TWidth+2)'(w_mag) * (SW+TWidth+2)'(r_q);
    assign w_res  = w_d[SW+1] ? (SW+2)'(w_va) - (SW+2)'(w_prod >> 16)
                              : (SW+2)'(w_va) + (SW+2)'(w_prod >> 16);

    logic [MW-1:0] w_rem2;
    assign w_rem2 = {r_rem[MW-2:0], 1'b0};

    assign o_job_ready = (r_state == BK_IDLE);
    assign o_valid = (r_state == BK_EMIT_INT) || (r_state == BK_EMIT_END)
                  || (r_state == BK_EMIT_MARK);

    always_comb begin
        o_vtx = '0;
        o_vertex_valid = 1'b1;
        o_polygon_end = 1'b0;
        case (r_state)
            BK_EMIT_INT: begin
                o_vtx = r_int;
                o_polygon_end = r_mark && !r_in2;
            end
            BK_EMIT_END: begin
                o_vtx = r_p2;
                o_polygon_end = r_mark;
            end
            BK_EMIT_MARK: begin
                o_vertex_valid = 1'b0;
                o_polygon_end = 1'b1;
            end
            default: o_vertex_valid = 1'b1;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: if (i_job_valid) n_state = BK_DIV;
            BK_DIV: begin
                if (r_in1 == r_in2) n_state = r_in2 ? BK_EMIT_END
                                            : (r_mark ? BK_EMIT_MARK : BK_IDLE);
                else if (r_sub == 2'd3 && r_bit == 5'd18) n_state = BK_LERP;
            end
            BK_LERP: if (r_lane == 4'(NumLanes + 1)) n_state = BK_EMIT_INT;
            BK_EMIT_INT: if (i_ready) n_state = r_in2 ? BK_EMIT_END : BK_IDLE;
            BK_EMIT_END, BK_EMIT_MARK: if (i_ready) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_p1 <= w_p1;
                r_p2 <= w_p2;
                r_in1 <= i_job[4];
                r_in2 <= i_job[3];
                r_mark <= i_job[1];
                r_sub <= 2'd0;
                r_bit <= 5'd0;
                r_lane <= 4'd0;
            end
            BK_DIV: begin
                case (r_sub)
                    2'd0: begin
                        r_e1x <= DW'($signed(r_p1[VW-1 -: SW])) - DW'(i_px);
                        r_e1y <= DW'($signed(r_p1[VW-SW-1 -: SW])) - DW'(i_py);
                        r_e2x <= DW'($signed(r_p2[VW-1 -: SW])) - DW'(i_px);
                        r_e2y <= DW'($signed(r_p2[VW-SW-1 -: SW])) - DW'(i_py);
                        r_sub <= 2'd1;
                    end
                    2'd1: begin
                        r_a1 <= PW'(r_e1x) * PW'(i_dy);
                        r_b1 <= PW'(r_e1y) * PW'(i_dx);
                        r_a2 <= PW'(r_e2x) * PW'(i_dy);
                        r_b2 <= PW'(r_e2y) * PW'(i_dx);
                        r_sub <= 2'd2;
                    end
                    2'd2: begin
                        r_n1 <= r_a1 < r_b1;
                        r_n2 <= r_a2 < r_b2;
                        r_m1 <= (r_a1 < r_b1) ? MW'(r_b1) - MW'(r_a1) : MW'(r_a1) - MW'(r_b1);
                        r_m2 <= (r_a2 < r_b2) ? MW'(r_b2) - MW'(r_a2) : MW'(r_a2) - MW'(r_b2);
                        r_sub <= 2'd3;
                    end
                    default: begin
                        if (r_bit == 5'd0) begin
                            r_den <= r_m1 + r_m2;
                            r_rem <= r_m1;
                            r_q <= '0;
                            if (r_m1 == '0 && r_m2 == '0) begin
                                r_bit <= 5'd18;
                            end else if (r_m1 != '0 && r_m2 != '0 && r_n1 == r_n2) begin
                                r_q <= (r_m1 > r_m2) ? TOne : '0;
                                r_bit <= 5'd18;
                            end else begin
                                r_bit <= 5'd1;
                            end
                        end else if (r_bit == 5'd1) begin
                            if (r_rem >= r_den) begin
                                r_rem <= r_rem - r_den;
                                r_q <= TWidth'(1);
                            end
                            r_bit <= 5'd2;
                        end else if (r_bit != 5'd18) begin
                            if (w_rem2 >= r_den) begin
                                r_rem <= w_rem2 - r_den;
                                r_q <= {r_q[TWidth-2:0], 1'b1};
                            end else begin
                                r_rem <= w_rem2;
                                r_q <= {r_q[TWidth-2:0], 1'b0};
                            end
                            r_bit <= r_bit + 5'd1;
                        end
                    end
                endcase
            end
            BK_LERP: begin
                if (r_lane == 4'd0) begin
                    r_int[VW-1 -: SW] <= w_res[SW-1:0];
                end else if (r_lane == 4'd1) begin
                    r_int[VW-SW-1 -: SW] <= w_res[SW-1:0];
                end else if (r_lane <= 4'(NumLanes + 1)) begin
                    r_int[(32'(r_lane) - 2) * LaneSlot +: LaneSlot] <=
                        LaneSlot'(w_res[AW-1:0]);
                end
                r_lane <= r_lane + 4'd1;
            end
            default: r_lane <= r_lane;
        endcase
    end
endmodule

### rtl/core/plc_checker.sv
// plc_checker: port-level assertions for polygon_line_clipper, bound to the top level
// depends on plc_pkg

module plc_checker
    import plc_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_ready,
    input logic o_vertex_valid,
    input logic o_polygon_end
);
    // a word without a vertex is only ever an end marker
    a_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_vertex_valid |-> o_polygon_end) else $error("empty word not end");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_polygon_end))
        else $error("output word dropped");

    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind polygon_line_clipper plc_checker u_plc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready),
    .o_vertex_valid(o_vertex_valid), .o_polygon_end(o_polygon_end)
);

### sim/polygon_line_clipper_test.sv
// polygon_line_clipper_test: self-checking bench for one line clip stage,
// predicts every output word from a local clip model and compares in order
// depends on plc_pkg and polygon_line_clipper
`timescale 1ns / 1ps

module polygon_line_clipper_test;
    import plc_pkg::*;

    localparam int SW = 24;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic [NormWidth-1:0] nrm;
        logic [PosWidth-1:0]  pos;
        logic [ProjWidth-1:0] prj;
        logic                 last;
    } t_vertex;

    typedef struct {
        logic signed [SW-1:0] x;
        logic signed [SW-1:0] y;
        logic [NormWidth-1:0] nrm;
        logic [PosWidth-1:0]  pos;
        logic [ProjWidth-1:0] prj;
        logic                 vv;
        logic                 pe;
    } t_clip_word;

    logic i_clk, i_rst_n;
    logic i_cfg_we;
    logic [CfgIdxWidth-1:0] i_cfg_index;
    logic [SW-1:0] i_cfg_data;
    logic i_valid, o_ready;
    logic signed [SW-1:0] i_screen_x, i_screen_y;
    logic [NormWidth-1:0] i_normal_lanes;
    logic [PosWidth-1:0] i_position_lanes;
    logic [ProjWidth-1:0] i_projected_lanes;
    logic i_last_vertex;
    logic o_valid, i_ready;
    logic signed [SW-1:0] o_out_screen_x, o_out_screen_y;
    logic [NormWidth-1:0] o_out_normal_lanes;
    logic [PosWidth-1:0] o_out_position_lanes;
    logic [ProjWidth-1:0] o_out_projected_lanes;
    logic o_vertex_valid, o_polygon_end;

    polygon_line_clipper dut (.*);

    // clip model state
    logic signed [SW-1:0] line_px, line_py, line_dx, line_dy;
    t_vertex first_v, prev_v;
    logic first_in, prev_in, have_first;
    t_clip_word clip_words_due[$];

    int n_vertices, n_words, n_settings, n_mismatch;
    logic calm, hold_req;
    int hold_left, quiet_cycles;

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    function automatic longint side_of(t_vertex v);
        return (longint'(v.x) - longint'(line_px)) * longint'(line_dy)
             - (longint'(v.y) - longint'(line_py)) * longint'(line_dx);
    endfunction

    function automatic logic [TWidth-1:0] crossing_t(t_vertex a, t_vertex b);
        longint s1, s2;
        logic [127:0] m1, m2;
        s1 = side_of(a);
        s2 = side_of(b);
        m1 = 128'(s1 < 0 ? -s1 : s1);
        m2 = 128'(s2 < 0 ? -s2 : s2);
        if (m1 == 0 && m2 == 0) return '0;
        if (m1 != 0 && m2 != 0 && ((s1 < 0) == (s2 < 0))) return (m1 > m2) ? TOne : '0;
        return TWidth'((m1 << 16) / (m1 + m2));
    endfunction

    function automatic longint blend(longint a, longint b, logic [TWidth-1:0] t);
        longint d, tt;
        d = b - a;
        tt = longint'({47'b0, t});
        if (d < 0) return a - (((-d) * tt) >> 16);
        return a + ((d * tt) >> 16);
    endfunction

    function automatic logic [63:0] blend_lanes(logic [63:0] a, logic [63:0] b, int n,
                                                logic [TWidth-1:0] t);
        logic [63:0] r;
        longint va, vb;
        r = '0;
        for (int i = 0; i < n; i++) begin
            va = longint'($signed(a[16*i +: 16]));
            vb = longint'($signed(b[16*i +: 16]));
            r[16*i +: 16] = 16'(blend(va, vb, t));
        end
        return r;
    endfunction

    function automatic t_clip_word vertex_word(t_vertex v);
        t_clip_word w;
        w.x = v.x;
        w.y = v.y;
        w.nrm = v.nrm;
        w.pos = v.pos;
        w.prj = v.prj;
        w.vv = 1'b1;
        w.pe = 1'b0;
        return w;
    endfunction

    task automatic queue_word(t_clip_word w);
        clip_words_due = {clip_words_due, w};
    endtask

    task automatic clip_edge(t_vertex a, logic a_in, t_vertex b, logic b_in);
        t_clip_word w;
        logic [TWidth-1:0] t;
        if (a_in != b_in) begin
            t = crossing_t(a, b);
            w.x = SW'(blend(longint'(a.x), longint'(b.x), t));
            w.y = SW'(blend(longint'(a.y), longint'(b.y), t));
            w.nrm = NormWidth'(blend_lanes(64'(a.nrm), 64'(b.nrm), 3, t));
            w.pos = PosWidth'(blend_lanes(64'(a.pos), 64'(b.pos), 3, t));
            w.prj = blend_lanes(a.prj, b.prj, 4, t);
            w.vv = 1'b1;
            w.pe = 1'b0;
            queue_word(w);
        end
        if (b_in) queue_word(vertex_word(b));
    endtask

    task automatic predict_clip(t_vertex v);
        logic v_in;
        int base;
        t_clip_word w;
        base = clip_words_due.size();
        v_in = side_of(v) < 0;
        if (!have_first) begin
            first_v = v;
            first_in = v_in;
            have_first = 1'b1;
        end else begin
            clip_edge(prev_v, prev_in, v, v_in);
        end
        prev_v = v;
        prev_in = v_in;
        if (v.last) begin
            clip_edge(prev_v, prev_in, first_v, first_in);
            have_first = 1'b0;
            if (clip_words_due.size() == base) begin
                w = '{default: '0};
                w.pe = 1'b1;
                queue_word(w);
            end else begin
                clip_words_due[clip_words_due.size()-1].pe = 1'b1;
            end
        end
    endtask

    task automatic send_vertex(t_vertex v);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = ($urandom_range(0, 6) == 0) ? $urandom_range(12, 50) : $urandom_range(1, 3);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_screen_x <= v.x;
        i_screen_y <= v.y;
        i_normal_lanes <= v.nrm;
        i_position_lanes <= v.pos;
        i_projected_lanes <= v.prj;
        i_last_vertex <= v.last;
        do @(negedge i_clk); while (!o_ready);
        predict_clip(v);
        n_vertices++;
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (clip_words_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(int unsigned idx, logic signed [SW-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CfgIdxWidth'(idx);
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            RegLinePointX: line_px = val;
            RegLinePointY: line_py = val;
            RegLineDirX:   line_dx = val;
            default:       line_dy = val;
        endcase
    endtask

    task automatic set_line(longint px, longint py, longint dx, longint dy);
        drain_results();
        write_reg(RegLinePointX, SW'(px));
        write_reg(RegLinePointY, SW'(py));
        write_reg(RegLineDirX, SW'(dx));
        write_reg(RegLineDirY, SW'(dy));
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic t_vertex make_vertex(longint x, longint y, logic last);
        t_vertex v;
        v.x = SW'(x);
        v.y = SW'(y);
        v.nrm = NormWidth'({$urandom, $urandom});
        v.pos = PosWidth'({$urandom, $urandom});
        v.prj = {$urandom, $urandom};
        v.last = last;
        return v;
    endfunction

    function automatic t_vertex near_line_vertex(logic last);
        if ($urandom_range(0, 9) == 0)
            return make_vertex(longint'($signed(SW'($urandom))),
                               longint'($signed(SW'($urandom))), last);
        return make_vertex(longint'(line_px) + $signed($urandom_range(0, 8000)) - 4000,
                           longint'(line_py) + $signed($urandom_range(0, 8000)) - 4000, last);
    endfunction

    task automatic send_polygon(int n);
        for (int i = 0; i < n; i++) send_vertex(near_line_vertex(i == n - 1));
    endtask

    // default line: inside means y above zero
    task automatic test_default_line();
        send_vertex(make_vertex(0, 256, 1'b0));
        send_vertex(make_vertex(512, -256, 1'b0));
        send_vertex(make_vertex(-512, -256, 1'b1));
        send_vertex(make_vertex(10, 100, 1'b0));
        send_vertex(make_vertex(20, 200, 1'b0));
        send_vertex(make_vertex(30, 300, 1'b1));
        send_vertex(make_vertex(10, -100, 1'b0));
        send_vertex(make_vertex(20, -200, 1'b1));
    endtask

    task automatic test_special_cases();
        t_vertex v;
        send_vertex(make_vertex(77, 99, 1'b1));
        send_vertex(make_vertex(77, -99, 1'b1));
        send_vertex(make_vertex(500, 0, 1'b0));
        send_vertex(make_vertex(-300, 400, 1'b0));
        send_vertex(make_vertex(0, 0, 1'b1));
        v = make_vertex(-8388608, 8388607, 1'b0);
        v.nrm = '1; v.pos = '1; v.prj = '1;
        send_vertex(v);
        v = make_vertex(8388607, -8388608, 1'b1);
        v.nrm = '0; v.pos = '0; v.prj = '0;
        send_vertex(v);
    endtask

    // side flags kept from before a mid-polygon line change
    task automatic test_stale_sides();
        send_vertex(make_vertex(100, 300, 1'b0));
        send_vertex(make_vertex(200, -300, 1'b0));
        set_line(0, 1000, 1, 0);
        send_vertex(make_vertex(-100, 500, 1'b0));
        send_vertex(make_vertex(50, 2000, 1'b1));
        set_line(0, 0, 0, 0);
        send_polygon(3);
        send_polygon(1);
    endtask

    task automatic test_line_extremes();
        set_line(8388607, -8388608, -8388608, 8388607);
        send_polygon(4);
        send_polygon(3);
        set_line(-8388608, 8388607, 8388607, -8388608);
        send_polygon(4);
        send_polygon(2);
    endtask

    task automatic test_random_polygons(int n_items);
        int start;
        start = n_vertices;
        while (n_vertices - start < n_items) begin
            if ($urandom_range(0, 3) == 0) begin
                set_line($signed($urandom_range(0, 4000)) - 2000,
                         $signed($urandom_range(0, 4000)) - 2000,
                         $signed($urandom_range(0, 1024)) - 512,
                         $signed($urandom_range(0, 1024)) - 512);
            end
            calm = ($urandom_range(0, 4) == 0);
            send_polygon($urandom_range(1, 6));
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        i_valid <= 1'b0;
        @(negedge i_clk);
        hold_req = 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < 4; i++) send_polygon(4);
        drain_results();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            hold_left <= 0;
        end else if (hold_req) begin
            hold_req <= 1'b0;
            hold_left <= 400;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 11) == 0) begin
            hold_left <= ($urandom_range(0, 5) == 0) ? $urandom_range(15, 60)
                                                     : $urandom_range(0, 2);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        t_clip_word e;
        if (o_valid && i_ready) begin
            n_words++;
            if (clip_words_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected word: x=%0d y=%0d vv=%b pe=%b",
                                               o_out_screen_x, o_out_screen_y,
                                               o_vertex_valid, o_polygon_end);
            end else begin
                e = clip_words_due.pop_front();
                if (o_out_screen_x !== e.x || o_out_screen_y !== e.y
                        || o_out_normal_lanes !== e.nrm || o_out_position_lanes !== e.pos
                        || o_out_projected_lanes !== e.prj || o_vertex_valid !== e.vv
                        || o_polygon_end !== e.pe) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("word %0d mismatch: expected x=%0d y=%0d nrm=%h pos=%h",
                                 n_words, e.x, e.y, e.nrm, e.pos);
                        $display("    expected prj=%h vv=%b pe=%b", e.prj, e.vv, e.pe);
                        $display("    actual x=%0d y=%0d nrm=%h pos=%h",
                                 o_out_screen_x, o_out_screen_y, o_out_normal_lanes,
                                 o_out_position_lanes);
                        $display("    actual prj=%h vv=%b pe=%b", o_out_projected_lanes,
                                 o_vertex_valid, o_polygon_end);
                    end
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_screen_x = '0;
        i_screen_y = '0;
        i_normal_lanes = '0;
        i_position_lanes = '0;
        i_projected_lanes = '0;
        i_last_vertex = 1'b0;
        calm = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        n_vertices = 0;
        n_words = 0;
        n_settings = 0;
        n_mismatch = 0;
        line_px = '0;
        line_py = '0;
        line_dx = 1;
        line_dy = '0;
        have_first = 1'b0;
        first_in = 1'b0;
        prev_in = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_line();
        test_special_cases();
        test_stale_sides();
        test_line_extremes();
        test_backpressure();
        test_random_polygons(80);
        drain_results();

        $display("clipped %0d vertices under %0d line settings, %0d output words checked",
                 n_vertices, n_settings, n_words);
        if (n_mismatch == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", n_mismatch);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
